// ===== design/wma_pkg.sv =====
// Shared types, widths and codes of the weighted moving average block.
`timescale 1ns / 1ps
`default_nettype none
package wma_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int NUM_W        = 7;
  localparam int TAP_W        = 3;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 4;
  localparam int WSUM_W       = 19;
  localparam int PROD_W       = 32;
  localparam int ACC_W        = 34;
  localparam int QUO_W        = 18;
  localparam int DMAG_W       = 18;
  localparam int DSH_W        = DMAG_W + QUO_W - 1;
  localparam int STEP_W       = 5;
  localparam int MIN_TAPS     = 3;
  localparam int MAX_TAPS_DEF = 7;

  localparam logic [IDX_W-1:0]    REG_TAP_COUNT = 3'd0;
  localparam logic [IDX_W-1:0]    REG_WEIGHT_0  = 3'd1;
  localparam logic [CNT_W-1:0]    COUNT_MAX     = 4'd15;
  localparam logic [SAMPLE_W-1:0] VAL_MAX       = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] VAL_MIN       = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAPS = 2'd1,
    ST_ZERO_SUM = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_ABS,
    BK_DIV,
    BK_FIN,
    BK_EMIT
  } back_state_e;

  typedef logic [NUM_W-1:0][SAMPLE_W-1:0] weights_t;

  typedef struct packed {
    logic                     busy;
    logic [TAP_W-1:0]         taps;
    logic signed [WSUM_W-1:0] wsum;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic       lead;
    logic       calc;
    logic [1:0] trail;
    logic       eos;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage
`default_nettype wire

// ===== design/wma_cfg.sv =====
// Configuration registers and serial refresh of the weight sum.
`timescale 1ns / 1ps
`default_nettype none
module wma_cfg
  import wma_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [SAMPLE_W-1:0] cfg_data_i,
  output cfg_t                     cfg_o,
  output weights_t                 weights_o
);

  logic [TAP_W-1:0]         taps_q;
  weights_t                 weights_q;
  logic signed [WSUM_W-1:0] wsum_q;
  logic signed [WSUM_W-1:0] sw_acc_q;
  logic [IDX_W-1:0]         sw_cnt_q;
  logic                     busy_q;
  logic [IDX_W-1:0]         widx;
  logic signed [WSUM_W-1:0] term;

  assign widx = IDX_W'(cfg_index_i - REG_WEIGHT_0);
  assign term = (sw_cnt_q < taps_q) ? WSUM_W'($signed(weights_q[sw_cnt_q])) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q    <= TAP_W'(MIN_TAPS);
      weights_q <= {{(NUM_W - 3){16'd0}}, {3{16'd1}}};
      wsum_q    <= 19'sd3;
      sw_acc_q  <= '0;
      sw_cnt_q  <= '0;
      busy_q    <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_TAP_COUNT) begin
        taps_q <= cfg_data_i[TAP_W-1:0];
      end else begin
        weights_q[widx] <= cfg_data_i;
      end
      // restart the sum sweep on every write
      busy_q   <= 1'b1;
      sw_cnt_q <= '0;
      sw_acc_q <= '0;
    end else if (busy_q) begin
      if (sw_cnt_q == IDX_W'(NUM_W - 1)) begin
        wsum_q <= sw_acc_q + term;
        busy_q <= 1'b0;
      end else begin
        sw_acc_q <= sw_acc_q + term;
        sw_cnt_q <= sw_cnt_q + 1'b1;
      end
    end
  end

  assign cfg_o.busy = busy_q;
  assign cfg_o.taps = taps_q;
  assign cfg_o.wsum = wsum_q;
  assign weights_o  = weights_q;

endmodule
`default_nettype wire

// ===== design/wma_front.sv =====
// Front end: sample window, position count and classification of each request.
`timescale 1ns / 1ps
`default_nettype none
module wma_front
  import wma_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [SAMPLE_W-1:0]                  sample_i,
  input  wire logic                                 end_of_series_i,
  input  wire cfg_t                                 cfg_i,
  input  wire logic                                 q_full_i,
  output logic                                      push_o,
  output job_t                                      job_o,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]         win_o
);

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win_q;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win_d;
  logic [CNT_W-1:0]                  seen_q;
  logic [CNT_W-1:0]                  seen_d;
  logic                              accept;
  logic                              bad_taps;
  logic [1:0]                        half;
  logic [CNT_W-1:0]                  half_w;
  logic [CNT_W-1:0]                  mid_trail;
  logic                              lead;
  logic                              calc;
  logic [1:0]                        trail;
  job_t                              job;

  assign in_stall_o = cfg_i.busy | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    win_d = win_q;
    for (int d = MAX_TAPS - 1; d > 0; d--) begin
      win_d[d] = win_q[d-1];
    end
    win_d[0] = sample_i;
  end

  assign seen_d = end_of_series_i ? '0 :
                  (seen_q == COUNT_MAX) ? COUNT_MAX : seen_q + 1'b1;

  assign bad_taps = ~cfg_i.taps[0] || (cfg_i.taps < TAP_W'(MIN_TAPS)) ||
                    (cfg_i.taps > TAP_W'(MAX_TAPS));
  assign half      = cfg_i.taps[2:1];
  assign half_w    = CNT_W'(half);
  assign lead      = seen_q < half_w;
  assign calc      = seen_q >= {half_w[CNT_W-2:0], 1'b0};
  assign mid_trail = seen_q - half_w + 1'b1;

  always_comb begin
    trail = 2'd0;
    if (end_of_series_i) begin
      if (calc) begin
        trail = half;
      end else if (!lead) begin
        trail = mid_trail[1:0];
      end
    end
  end

  always_comb begin
    job.status = ST_OK;
    job.lead   = lead;
    job.calc   = calc;
    job.trail  = trail;
    job.eos    = end_of_series_i;
    // an error gives exactly one result, whatever the position
    if (bad_taps || cfg_i.wsum == '0) begin
      job.status = bad_taps ? ST_BAD_TAPS : ST_ZERO_SUM;
      job.lead   = 1'b0;
      job.calc   = 1'b0;
      job.trail  = 2'd0;
    end
  end

  assign push_o = accept && (job.status != ST_OK || job.lead || job.calc ||
                             job.trail != 2'd0);
  assign job_o  = job;
  assign win_o  = win_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/wma_queue.sv =====
// Two-entry queue between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none
module wma_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   valid_o,
  output logic                   full_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/wma_back.sv =====
// Back end: serial multiply-accumulate, serial divider and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
module wma_back
  import wma_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire job_t                         q_job_i,
  input  wire logic [MAX_TAPS-1:0][SAMPLE_W-1:0] q_win_i,
  output logic                              q_pop_o,
  input  wire cfg_t                         cfg_i,
  input  wire weights_t                     weights_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [SAMPLE_W-1:0]               value_o,
  output logic                              valid_res_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);

  localparam int WIN_IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  back_state_e state_q, state_d;

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] win_q;
  logic                     eos_q;
  logic [1:0]               trail_q;
  logic [TAP_W-1:0]         k_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     neg_q;
  logic [ACC_W-1:0]         rem_q;
  logic [DSH_W-1:0]         dsh_q;
  logic [QUO_W-1:0]         quo_q;
  logic [STEP_W-1:0]        step_q;
  logic [SAMPLE_W-1:0]      res_value_q;
  logic                     res_valid_q;
  status_e                  res_status_q;
  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_value_q;
  logic                     out_vres_q;
  status_e                  out_status_q;
  logic                     out_last_q;

  logic                     out_free;
  logic                     emit;
  logic                     head;
  logic                     in_taps;
  logic [TAP_W-1:0]         tap_sel;
  logic [TAP_W-1:0]         win_sel;
  logic signed [SAMPLE_W-1:0] w_sel;
  logic signed [SAMPLE_W-1:0] x_sel;
  logic [ACC_W-1:0]         acc_mag;
  logic [WSUM_W-1:0]        wsum_mag;
  logic                     ge;
  logic                     sat;
  logic [SAMPLE_W-1:0]      fin_value;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign head     = q_job_i.status != ST_OK || q_job_i.lead || q_job_i.calc;

  // next state and handshake control
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_job_i.calc) begin
            state_d = BK_MAC;
          end else if (head || q_job_i.trail != 2'd0) begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_MAC: begin
        if (k_q == cfg_i.taps) begin
          state_d = BK_ABS;
        end
      end
      BK_ABS: state_d = BK_DIV;
      BK_DIV: begin
        if (step_q == '0) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (trail_q == 2'd0) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // multiply-accumulate operands, one tap a cycle
  assign in_taps = k_q < cfg_i.taps;
  assign tap_sel = in_taps ? k_q : '0;
  assign win_sel = in_taps ? TAP_W'(cfg_i.taps - 1'b1 - k_q) : '0;
  assign w_sel   = $signed(weights_i[tap_sel]);
  assign x_sel   = $signed(win_q[win_sel[WIN_IW-1:0]]);

  assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign wsum_mag = cfg_i.wsum[WSUM_W-1] ? WSUM_W'(-cfg_i.wsum) : WSUM_W'(cfg_i.wsum);

  assign ge = DSH_W'(rem_q) >= dsh_q;

  // clamp quotients of 2^15 and above
  assign sat       = quo_q[QUO_W-1:SAMPLE_W-1] != '0;
  assign fin_value = sat ? (neg_q ? VAL_MIN : VAL_MAX) :
                     neg_q ? (~quo_q[SAMPLE_W-1:0] + 1'b1) : quo_q[SAMPLE_W-1:0];

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          win_q        <= q_win_i;
          eos_q        <= q_job_i.eos;
          trail_q      <= (head || q_job_i.trail == 2'd0) ? q_job_i.trail :
                          q_job_i.trail - 2'd1;
          k_q          <= '0;
          acc_q        <= '0;
          prod_vld_q   <= 1'b0;
          res_value_q  <= '0;
          res_valid_q  <= 1'b0;
          res_status_q <= q_job_i.status;
        end
      end
      BK_MAC: begin
        prod_q     <= PROD_W'(w_sel * x_sel);
        prod_vld_q <= in_taps;
        if (prod_vld_q) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
        k_q <= k_q + 1'b1;
      end
      BK_ABS: begin
        neg_q  <= acc_q[ACC_W-1] ^ cfg_i.wsum[WSUM_W-1];
        rem_q  <= acc_mag;
        dsh_q  <= {wsum_mag[DMAG_W-1:0], (QUO_W - 1)'(0)};
        quo_q  <= '0;
        step_q <= STEP_W'(QUO_W - 1);
      end
      BK_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dsh_q[ACC_W-1:0];
        end
        quo_q  <= {quo_q[QUO_W-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - 1'b1;
      end
      BK_FIN: begin
        res_value_q  <= fin_value;
        res_valid_q  <= 1'b1;
        res_status_q <= ST_OK;
      end
      BK_EMIT: begin
        if (emit && trail_q != 2'd0) begin
          res_value_q  <= '0;
          res_valid_q  <= 1'b0;
          res_status_q <= ST_OK;
          trail_q      <= trail_q - 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= res_value_q;
      out_vres_q   <= res_valid_q;
      out_status_q <= res_status_q;
      out_last_q   <= eos_q && trail_q == 2'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign valid_res_o = out_vres_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_MAC |-> k_q <= cfg_i.taps)
    else $error("tap counter ran past the tap count");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV && step_q == '0) |=> state_q == BK_FIN)
    else $error("divider did not finish after its last step");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_FIN |=> (state_q == BK_EMIT && res_valid_q))
    else $error("computed result not staged as valid");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == BK_EMIT)
    else $error("output loaded outside the emit state");

endmodule
`default_nettype wire

// ===== design/weighted_moving_average.sv =====
// Centered weighted moving average: top level.
//
// Input channel: sample_i and end_of_series_i, taken when in_valid_i is high
// and in_stall_o is low. Output channel: value_o, valid_res_o, status_o and
// last_o, taken when out_valid_o is high and out_stall_i is low; a held
// result stays put while out_stall_i is high.
// Each request yields zero to four results, one per series position; an
// error (bad tap count, zero weight sum) yields exactly one result.
// A request with a computed result passes through the back end's
// multiply-accumulate, its serial divider and the hand-over to the output,
// then emits its results one at a time; the divider is its longest step.
// Requests with invalid results go straight to emitting. The back end takes
// the next request only once the last has emitted all of its results.
// A two-entry queue lets the front take requests while the back works; the
// input stalls when it is full, and while the weight sum is refreshed after
// each configuration write.
// Reset restores the register defaults (three taps, weights 1,1,1) and
// empties the position count, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module weighted_moving_average
  import wma_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [SAMPLE_W-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                end_of_series_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SAMPLE_W-1:0]      value_o,
  output logic                     valid_res_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int WIN_BITS = MAX_TAPS * SAMPLE_W;
  localparam int Q_W      = JOB_W + WIN_BITS;

  cfg_t     cfg;
  weights_t weights;
  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  job_t     f_job;
  job_t     b_job;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] f_win;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] b_win;
  logic [Q_W-1:0] q_in;
  logic [Q_W-1:0] q_out;

  wma_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .weights_o   (weights)
  );

  wma_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .end_of_series_i (end_of_series_i),
    .cfg_i           (cfg),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (f_job),
    .win_o           (f_win)
  );

  assign q_in  = {f_job, f_win};
  assign b_job = job_t'(q_out[Q_W-1:WIN_BITS]);
  assign b_win = q_out[WIN_BITS-1:0];

  wma_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  wma_back #(
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (b_job),
    .q_win_i     (b_win),
    .q_pop_o     (pop),
    .cfg_i       (cfg),
    .weights_i   (weights),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .valid_res_o (valid_res_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_weighted_moving_average.sv =====
// Self-checking testbench for the weighted moving average block.
`timescale 1ns / 1ps
module tb_weighted_moving_average;
  import wma_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 25;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_NS     = 6_000_000;
  localparam int POINTS_MAX   = 4;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    KERNEL_T3,
    KERNEL_T5,
    KERNEL_T7,
    KERNEL_EXTREME,
    KERNEL_EQUAL,
    KERNEL_FAULT
  } kernel_kind_e;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                valid_res;
    status_e             status;
    logic                last;
  } point_t;

  // Tracks the filter state and holds the series positions still due.
  class average_tracker;
    logic [TAP_W-1:0]    tap_count;
    logic [SAMPLE_W-1:0] weight [NUM_W];
    logic [SAMPLE_W-1:0] history [NUM_W];
    int                  seen;
    point_t              due_positions [$];
    int                  n_samples;
    int                  n_points;
    int                  n_computed;
    int                  n_flagged;
    int                  mismatches;

    function new();
      tap_count = TAP_W'(MIN_TAPS);
      for (int k = 0; k < NUM_W; k++) begin
        weight[k]  = (k < MIN_TAPS) ? 16'd1 : 16'd0;
        history[k] = '0;
      end
      seen       = 0;
      n_samples  = 0;
      n_points   = 0;
      n_computed = 0;
      n_flagged  = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_positions.size();
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      if (idx == REG_TAP_COUNT) tap_count = data[TAP_W-1:0];
      else weight[int'(idx) - int'(REG_WEIGHT_0)] = data;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s, logic eos);
      int     j;
      int     half;
      int     trail;
      int     wsum;
      int     n;
      longint acc;
      longint q;
      status_e st;
      point_t pts [POINTS_MAX];
      j = seen;
      n_samples++;
      for (int d = NUM_W - 1; d > 0; d--) history[d] = history[d-1];
      history[0] = s;
      seen = eos ? 0 : ((j < int'(COUNT_MAX)) ? j + 1 : int'(COUNT_MAX));
      st   = ST_OK;
      wsum = 0;
      if (!tap_count[0] || tap_count < MIN_TAPS || tap_count > MAX_TAPS_DEF) begin
        st = ST_BAD_TAPS;
      end else begin
        for (int k = 0; k < int'(tap_count); k++) wsum += int'($signed(weight[k]));
        if (wsum == 0) st = ST_ZERO_SUM;
      end
      // Faulty settings give exactly one flagged position per request.
      if (st != ST_OK) begin
        due_positions.push_back('{value: '0, valid_res: 1'b0, status: st, last: eos});
        n_flagged++;
        return;
      end
      half = int'(tap_count) >> 1;
      n    = 0;
      if (j < half) begin
        pts[n++] = '{value: '0, valid_res: 1'b0, status: ST_OK, last: 1'b0};
      end else if (j >= 2 * half) begin
        acc = 0;
        for (int k = 0; k < int'(tap_count); k++)
          acc += longint'($signed(weight[k])) *
                 longint'($signed(history[int'(tap_count) - 1 - k]));
        q = acc / longint'(wsum);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        pts[n++] = '{value: q[SAMPLE_W-1:0], valid_res: 1'b1, status: ST_OK, last: 1'b0};
        n_computed++;
      end
      if (eos) begin
        trail = 0;
        if (j >= 2 * half) trail = half;
        else if (j >= half) trail = j - half + 1;
        for (int t = 0; t < trail && n < POINTS_MAX; t++)
          pts[n++] = '{value: '0, valid_res: 1'b0, status: ST_OK, last: 1'b0};
        if (n > 0) pts[n-1].last = 1'b1;
      end
      for (int k = 0; k < n; k++) due_positions.push_back(pts[k]);
    endfunction

    function void match_result(logic [SAMPLE_W-1:0] value, logic vres, logic [1:0] status,
                               logic last);
      point_t e;
      if (due_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: result with nothing due: value %h valid %b status %0d last %b",
                   value, vres, status, last);
        return;
      end
      e = due_positions.pop_front();
      n_points++;
      if (value !== e.value || vres !== e.valid_res || status !== e.status ||
          last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch at result %0d: exp value %h valid %b status %0d last %b",
                   n_points, e.value, e.valid_res, e.status, e.last);
          $display("  got value %h valid %b status %0d last %b", value, vres, status, last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i     = '0;
  logic [SAMPLE_W-1:0] cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i        = '0;
  logic                end_of_series_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [SAMPLE_W-1:0] value_o;
  logic                valid_res_o;
  logic [1:0]          status_o;
  logic                last_o;

  int gap_pct    = 0;
  int stall_pct  = 0;
  int n_settings = 0;

  average_tracker sb = new();

  weighted_moving_average u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .end_of_series_i (end_of_series_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o),
    .valid_res_o     (valid_res_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  initial begin
    #LIMIT_NS;
    $display("weighted_moving_average verification failed");
    $finish;
  end

  // Take results and draw the next stall in one place.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.match_result(value_o, valid_res_o, status_o, last_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send(input logic [SAMPLE_W-1:0] s, input logic eos);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= s;
    end_of_series_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_sample(s, eos);
  endtask

  // Drop valid and wait for every due position to come out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Drain, then let the block idle before going on.
  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_kernel(input logic [TAP_W-1:0] taps, input weights_t w);
    write_reg(REG_TAP_COUNT, {13'($urandom), taps});
    for (int k = 0; k < NUM_W; k++) write_reg(IDX_W'(int'(REG_WEIGHT_0) + k), w[k]);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        gap_pct = 85;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct <= 85;
      end
      default: begin
        gap_pct = 30;
        stall_pct <= 30;
      end
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_weight();
    case ($urandom_range(2))
      0:       return SAMPLE_W'($urandom);
      1:       return SAMPLE_W'($urandom_range(16)) - 16'd8;
      default: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0, 1: return SAMPLE_W'($urandom);
      2:    return SAMPLE_W'($urandom_range(64)) - 16'd32;
      default: begin
        case ($urandom_range(3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  function automatic int kernel_sum(input logic [TAP_W-1:0] taps, input weights_t w);
    int s;
    s = 0;
    for (int k = 0; k < int'(taps); k++) s += int'($signed(w[k]));
    return s;
  endfunction

  task automatic pick_kernel(input kernel_kind_e kind, input int ph,
                             output logic [TAP_W-1:0] taps, output weights_t w);
    logic [TAP_W-1:0] bad_taps [5];
    logic [SAMPLE_W-1:0] level;
    int s;
    bad_taps = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd6};
    for (int k = 0; k < NUM_W; k++) w[k] = rand_weight();
    case (kind)
      KERNEL_T3: taps = 3'd3;
      KERNEL_T5: taps = 3'd5;
      KERNEL_T7: taps = 3'd7;
      KERNEL_EXTREME: begin
        taps = 3'd7;
        for (int k = 0; k < NUM_W; k++) w[k] = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      end
      KERNEL_EQUAL: begin
        taps  = $urandom_range(1) ? 3'd3 : 3'd5;
        level = SAMPLE_W'($urandom_range(1, 300));
        for (int k = 0; k < NUM_W; k++) w[k] = level;
      end
      default: begin
        if (ph < PHASES / 2) begin
          taps = bad_taps[$urandom_range(4)];
        end else begin
          // Balance the last tap in use against the others.
          taps = TAP_W'(2 * $urandom_range(1, 3) + 1);
          s = 0;
          for (int k = 0; k < int'(taps) - 1; k++) begin
            w[k] = SAMPLE_W'($urandom_range(2000)) - 16'd1000;
            s += int'($signed(w[k]));
          end
          w[int'(taps) - 1] = SAMPLE_W'(-s);
        end
      end
    endcase
    if (kind != KERNEL_FAULT)
      while (kernel_sum(taps, w) == 0) w[0] = rand_weight();
  endtask

  initial begin
    logic [TAP_W-1:0] taps;
    weights_t         w;
    logic             eos;
    int               series_left;
    logic             ok;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset kernel: extremes, a one-sample series and a two-sample series.
    send(VAL_MAX, 1'b0);
    send(VAL_MIN, 1'b0);
    send(VAL_MAX, 1'b0);
    send(16'h0000, 1'b0);
    send(16'hffff, 1'b1);
    send(16'h1234, 1'b1);
    send(VAL_MIN, 1'b0);
    send(VAL_MAX, 1'b1);

    // Drive the quotient into both saturation limits; unused taps hold junk.
    settle();
    w = {7{16'h5a5a}};
    w[0] = VAL_MAX;
    w[1] = VAL_MAX;
    w[2] = VAL_MIN;
    load_kernel(3'd3, w);
    send(VAL_MAX, 1'b0);
    send(VAL_MAX, 1'b0);
    send(VAL_MIN, 1'b0);
    send(VAL_MIN, 1'b0);
    send(VAL_MAX, 1'b1);

    // Weights in use sum to zero.
    settle();
    w = '0;
    w[0] = 16'd1;
    w[1] = 16'hffff;
    load_kernel(3'd3, w);
    send(16'h0100, 1'b0);
    send(16'h0200, 1'b1);

    // Even tap count.
    settle();
    w = {7{16'd1}};
    load_kernel(3'd4, w);
    send(16'haaaa, 1'b0);
    send(16'h5555, 1'b1);

    // Widest kernel, plain average, series giving the most results at its end.
    settle();
    load_kernel(3'd7, w);
    for (int i = 0; i < 8; i++) send(SAMPLE_W'(i * 1000 - 3000), i == 7);

    // Random phases; series run across kernel changes on purpose.
    series_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      pick_kernel(kernel_kind_e'(ph % 6), ph, taps, w);
      load_kernel(taps, w);
      set_idling(idle_mode_e'(ph % 4));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (series_left == 0)
          series_left = ($urandom_range(9) == 0) ? $urandom_range(14, 24)
                                                 : $urandom_range(1, 10);
        eos = (series_left == 1);
        series_left--;
        // Now and then cut a series short or let it run on.
        if ($urandom_range(19) == 0) begin
          eos = ~eos;
          if (eos) series_left = 0;
        end
        send(rand_sample(), eos);
        if (i == PHASE_ITEMS / 2) hold_until_drained();
      end
    end

    set_idling(IDLE_NONE);
    settle();
    $display("covered %0d requests over %0d kernel settings under four idling patterns",
             sb.n_samples, n_settings);
    $display("%0d results checked: %0d computed, %0d flagged, %0d mismatches",
             sb.n_points, sb.n_computed, sb.n_flagged, sb.mismatches);
    ok = (sb.mismatches == 0) && (sb.pending() == 0);
    if (ok) begin
      $display("weighted_moving_average verification clean");
    end else begin
      $display("weighted_moving_average verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wma_pkg.sv
design/wma_cfg.sv
design/wma_front.sv
design/wma_queue.sv
design/wma_back.sv
design/weighted_moving_average.sv
tb/tb_weighted_moving_average.sv
